// ===== rtl/three_point_circumradius_core_defines.svh =====
// Assertion macros shared by the circumradius core.
`ifndef THREE_POINT_CIRCUMRADIUS_CORE_DEFINES_SVH
`define THREE_POINT_CIRCUMRADIUS_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TPCR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");
`define TPCR_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TPCR_ASSERT_IMPLY(lbl, ante, cons)
`define TPCR_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/tpcr_pkg.sv =====
// Shared constants and types for the circumradius core.
package tpcr_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned RADIUS_BITS    = 32;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_COLLINEAR = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/tpcr_fifo.sv =====
// Short queue between the term front end and the solver back end.
module tpcr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = tpcr_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output tpcr_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/tpcr_front.sv =====
// Front end: bisector terms, determinant and collinear check, then queue push.
module tpcr_front #(
  parameter int unsigned COORD_BITS = tpcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic signed [COORD_BITS-1:0] x2_i,
  input  logic signed [COORD_BITS-1:0] y2_i,
  input  tpcr_pkg::q_stat_t            q_stat_i,
  output logic                         push_o,
  output logic [12*COORD_BITS+15-1:0]  entry_o
);

  localparam int unsigned N    = COORD_BITS;
  localparam int unsigned AW   = N + 2;
  localparam int unsigned CW   = 2 * N + 1;
  localparam int unsigned DETW = 2 * N + 4;
  localparam int unsigned SQW  = 2 * N;

  logic v1_q, v2_q, v3_q, adv;

  // stage 1
  logic signed [AW-1:0]  a1_q, b1_q, d1_q, e1_q;
  logic signed [SQW-1:0] sx0_q, sy0_q, sx1_q, sy1_q, sx2_q, sy2_q;
  logic signed [N-1:0]   x01_q, y01_q;
  logic signed [N:0]     dx1, dy1, dx2, dy2;
  // stage 2
  logic signed [AW-1:0]   a2_q, b2_q, d2_q, e2_q;
  logic signed [CW-1:0]   c2_q, f2_q;
  logic signed [2*AW-1:0] pbd_q, pea_q;
  logic signed [N-1:0]    x02_q, y02_q;
  // stage 3
  logic signed [AW-1:0]   a3_q, b3_q, d3_q, e3_q;
  logic signed [CW-1:0]   c3_q, f3_q;
  logic signed [DETW-1:0] det_q;
  logic                   col_q;
  logic signed [N-1:0]    x03_q, y03_q;

  // hold all stages while the last one waits on a full queue
  assign adv        = !v3_q || !q_stat_i.full;
  assign in_ready_o = adv;
  assign push_o     = v3_q && !q_stat_i.full;
  assign entry_o    = {col_q, det_q, c3_q, f3_q, a3_q, b3_q, d3_q, e3_q, x03_q, y03_q};

  assign dx1 = (N+1)'(x1_i) - (N+1)'(x0_i);
  assign dy1 = (N+1)'(y1_i) - (N+1)'(y0_i);
  assign dx2 = (N+1)'(x2_i) - (N+1)'(x1_i);
  assign dy2 = (N+1)'(y2_i) - (N+1)'(y1_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q  <= {dx1, 1'b0};
      b1_q  <= {dy1, 1'b0};
      d1_q  <= {dx2, 1'b0};
      e1_q  <= {dy2, 1'b0};
      sx0_q <= x0_i * x0_i;
      sy0_q <= y0_i * y0_i;
      sx1_q <= x1_i * x1_i;
      sy1_q <= y1_i * y1_i;
      sx2_q <= x2_i * x2_i;
      sy2_q <= y2_i * y2_i;
      x01_q <= x0_i;
      y01_q <= y0_i;

      a2_q  <= a1_q;
      b2_q  <= b1_q;
      d2_q  <= d1_q;
      e2_q  <= e1_q;
      c2_q  <= CW'(sx1_q) + CW'(sy1_q) - CW'(sx0_q) - CW'(sy0_q);
      f2_q  <= CW'(sx2_q) + CW'(sy2_q) - CW'(sx1_q) - CW'(sy1_q);
      pbd_q <= b1_q * d1_q;
      pea_q <= e1_q * a1_q;
      x02_q <= x01_q;
      y02_q <= y01_q;

      a3_q  <= a2_q;
      b3_q  <= b2_q;
      d3_q  <= d2_q;
      e3_q  <= e2_q;
      c3_q  <= c2_q;
      f3_q  <= f2_q;
      det_q <= DETW'(pbd_q) - DETW'(pea_q);
      col_q <= (pbd_q == pea_q);
      x03_q <= x02_q;
      y03_q <= y02_q;
    end
  end

endmodule

// ===== rtl/tpcr_back.sv =====
// Back end: center numerators, two pipelined dividers, offsets and square root.
module tpcr_back #(
  parameter int unsigned COORD_BITS = tpcr_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [12*COORD_BITS+15-1:0]      entry_i,
  input  tpcr_pkg::q_stat_t                q_stat_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tpcr_pkg::RADIUS_BITS-1:0] radius_o,
  output tpcr_pkg::status_e                status_o
);

  localparam int unsigned N     = COORD_BITS;
  localparam int unsigned AW    = N + 2;
  localparam int unsigned CW    = 2 * N + 1;
  localparam int unsigned DETW  = 2 * N + 4;
  localparam int unsigned NUMW  = 3 * N + 3;
  localparam int unsigned L     = CW / 2;
  localparam int unsigned HW    = CW - L;
  localparam int unsigned PW    = AW + HW;
  localparam int unsigned OW    = NUMW + 2;
  localparam int unsigned MW    = (OW > 33) ? OW : 33;
  localparam int unsigned SW    = 2 * N + 1;
  localparam int unsigned RB    = tpcr_pkg::RADIUS_BITS;
  localparam int unsigned SQ    = 2 * RB;
  localparam int unsigned TOTAL = NUMW + 8 + RB;

  logic                 adv;
  logic [TOTAL-1:0]     vld_q;

  logic                   col;
  logic signed [DETW-1:0] det;
  logic signed [CW-1:0]   c, f;
  logic signed [AW-1:0]   a, b, d, e;
  logic signed [N-1:0]    x0, y0;

  assign {col, det, c, f, a, b, d, e, x0, y0} = entry_i;

  // whole back pipeline moves together; a bubble is filled as it advances
  assign adv         = !vld_q[TOTAL-1] || out_ready_i;
  assign pop_o       = adv && !q_stat_i.empty;
  assign out_valid_o = vld_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[TOTAL-2:0], pop_o};
    end
  end

  // B1: partial products, wide operand split in halves
  logic signed [PW-1:0]   bf_h_q, bf_l_q, ec_h_q, ec_l_q, dc_h_q, dc_l_q, af_h_q, af_l_q;
  logic signed [DETW-1:0] det1_q;
  logic [SW-1:0]          side1_q;
  logic signed [HW-1:0]   f_hi, c_hi;
  logic signed [L:0]      f_lo, c_lo;

  assign f_hi = f[CW-1:L];
  assign c_hi = c[CW-1:L];
  assign f_lo = $signed({1'b0, f[L-1:0]});
  assign c_lo = $signed({1'b0, c[L-1:0]});

  // B2..B4
  logic signed [NUMW-1:0] bf_q, ec_q, dc_q, af_q, numx_q, numy_q;
  logic signed [DETW-1:0] det2_q, det3_q;
  logic [SW-1:0]          side2_q, side3_q;

  // divider lanes
  logic [DETW-1:0] rx [NUMW+1];
  logic [DETW-1:0] ry [NUMW+1];
  logic [NUMW-1:0] nx [NUMW+1];
  logic [NUMW-1:0] ny [NUMW+1];
  logic [NUMW-1:0] qx [NUMW+1];
  logic [NUMW-1:0] qy [NUMW+1];
  logic [DETW-1:0] dm [NUMW+1];
  logic            negx [NUMW+1];
  logic            negy [NUMW+1];
  logic [SW-1:0]   dside [NUMW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bf_h_q  <= b * f_hi;
      bf_l_q  <= b * f_lo;
      ec_h_q  <= e * c_hi;
      ec_l_q  <= e * c_lo;
      dc_h_q  <= d * c_hi;
      dc_l_q  <= d * c_lo;
      af_h_q  <= a * f_hi;
      af_l_q  <= a * f_lo;
      det1_q  <= det;
      side1_q <= {col, x0, y0};

      bf_q    <= (NUMW'(bf_h_q) <<< L) + NUMW'(bf_l_q);
      ec_q    <= (NUMW'(ec_h_q) <<< L) + NUMW'(ec_l_q);
      dc_q    <= (NUMW'(dc_h_q) <<< L) + NUMW'(dc_l_q);
      af_q    <= (NUMW'(af_h_q) <<< L) + NUMW'(af_l_q);
      det2_q  <= det1_q;
      side2_q <= side1_q;

      numx_q  <= bf_q - ec_q;
      numy_q  <= dc_q - af_q;
      det3_q  <= det2_q;
      side3_q <= side2_q;

      // split into sign and magnitude for the dividers
      negx[0]  <= numx_q[NUMW-1] ^ det3_q[DETW-1];
      negy[0]  <= numy_q[NUMW-1] ^ det3_q[DETW-1];
      nx[0]    <= numx_q[NUMW-1] ? NUMW'(-numx_q) : NUMW'(numx_q);
      ny[0]    <= numy_q[NUMW-1] ? NUMW'(-numy_q) : NUMW'(numy_q);
      dm[0]    <= det3_q[DETW-1] ? DETW'(-det3_q) : DETW'(det3_q);
      rx[0]    <= '0;
      ry[0]    <= '0;
      qx[0]    <= '0;
      qy[0]    <= '0;
      dside[0] <= side3_q;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < NUMW; k++) begin : g_div
    localparam int unsigned BI = NUMW - 1 - k;
    logic [DETW:0]   tx, ty;
    logic            gx, gy;
    logic [NUMW-1:0] qxn, qyn;

    always_comb begin
      tx  = {rx[k], nx[k][BI]};
      ty  = {ry[k], ny[k][BI]};
      gx  = tx >= {1'b0, dm[k]};
      gy  = ty >= {1'b0, dm[k]};
      qxn = qx[k];
      qyn = qy[k];
      qxn[BI] = gx;
      qyn[BI] = gy;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx[k+1]    <= DETW'(gx ? tx - {1'b0, dm[k]} : tx);
        ry[k+1]    <= DETW'(gy ? ty - {1'b0, dm[k]} : ty);
        qx[k+1]    <= qxn;
        qy[k+1]    <= qyn;
        nx[k+1]    <= nx[k];
        ny[k+1]    <= ny[k];
        dm[k+1]    <= dm[k];
        negx[k+1]  <= negx[k];
        negy[k+1]  <= negy[k];
        dside[k+1] <= dside[k];
      end
    end
  end

  // E1..E4: offsets from the first point, overflow, squares, sum
  logic signed [OW-1:0] qsx, qsy, offx_q, offy_q, absx, absy;
  logic signed [N-1:0]  bx, by;
  logic                 col_e1_q, col_e2_q, col_e3_q;
  logic [MW-1:0]        magx, magy;
  logic [RB-1:0]        mx_q, my_q;
  logic                 sat_e2_q, sat_e3_q;
  logic [SQ-1:0]        sqx_q, sqy_q;
  logic [SQ:0]          sum;

  assign bx   = dside[NUMW][2*N-1:N];
  assign by   = dside[NUMW][N-1:0];
  assign qsx  = negx[NUMW] ? -$signed({2'b00, qx[NUMW]}) : $signed({2'b00, qx[NUMW]});
  assign qsy  = negy[NUMW] ? -$signed({2'b00, qy[NUMW]}) : $signed({2'b00, qy[NUMW]});
  assign absx = offx_q[OW-1] ? -offx_q : offx_q;
  assign absy = offy_q[OW-1] ? -offy_q : offy_q;
  assign magx = MW'($unsigned(absx));
  assign magy = MW'($unsigned(absy));
  assign sum  = {1'b0, sqx_q} + {1'b0, sqy_q};

  // root stages
  logic [SQ-1:0] sn   [RB+1];
  logic [SQ-1:0] sres [RB+1];
  logic          ssat [RB+1];
  logic          scol [RB+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      offx_q   <= qsx - OW'(bx);
      offy_q   <= qsy - OW'(by);
      col_e1_q <= dside[NUMW][SW-1];

      mx_q     <= magx[RB-1:0];
      my_q     <= magy[RB-1:0];
      sat_e2_q <= (|magx[MW-1:RB]) || (|magy[MW-1:RB]);
      col_e2_q <= col_e1_q;

      sqx_q    <= SQ'(mx_q) * SQ'(mx_q);
      sqy_q    <= SQ'(my_q) * SQ'(my_q);
      sat_e3_q <= sat_e2_q;
      col_e3_q <= col_e2_q;

      sn[0]    <= sum[SQ-1:0];
      sres[0]  <= '0;
      ssat[0]  <= sat_e3_q || sum[SQ];
      scol[0]  <= col_e3_q;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam logic [SQ-1:0] BITV = SQ'(1) << (SQ - 2 - 2 * j);
    logic [SQ-1:0] t;
    logic          ge;

    assign t  = sres[j] + BITV;
    assign ge = sn[j] >= t;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sn[j+1]   <= ge ? sn[j] - t : sn[j];
        sres[j+1] <= ge ? (sres[j] >> 1) + BITV : sres[j] >> 1;
        ssat[j+1] <= ssat[j];
        scol[j+1] <= scol[j];
      end
    end
  end

  always_comb begin
    if (scol[RB]) begin
      radius_o = '0;
      status_o = tpcr_pkg::ST_COLLINEAR;
    end else if (ssat[RB]) begin
      radius_o = '1;
      status_o = tpcr_pkg::ST_SATURATED;
    end else begin
      radius_o = sres[RB][RB-1:0];
      status_o = tpcr_pkg::ST_VALID;
    end
  end

endmodule

// ===== rtl/three_point_circumradius_core.sv =====
// Throughput: one point triple per cycle while the output is not stalled, carried
// by the pipelined restoring dividers (one quotient bit per stage, 3*COORD_BITS+3
// stages) and the 32-stage square root.
// A four-entry queue splits the term front end from the solver back end.
// Reset clears all valid bits and empties the queue; data registers are not reset.
`include "three_point_circumradius_core_defines.svh"
module three_point_circumradius_core #(
  parameter int unsigned COORD_BITS = tpcr_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // radius
  output logic [tpcr_pkg::RADIUS_BITS-1:0]       m_axis_tdata,
  // status
  output logic [1:0]                             m_axis_tuser
);

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned EW = 12 * N + 15;

  logic              q_push, q_pop;
  logic [EW-1:0]     q_wdata, q_rdata;
  tpcr_pkg::q_stat_t q_stat;
  tpcr_pkg::status_e status;

  tpcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .x0_i       ($signed(s_axis_tdata[N-1:0])),
    .y0_i       ($signed(s_axis_tdata[2*N-1:N])),
    .x1_i       ($signed(s_axis_tdata[3*N-1:2*N])),
    .y1_i       ($signed(s_axis_tdata[4*N-1:3*N])),
    .x2_i       ($signed(s_axis_tdata[5*N-1:4*N])),
    .y2_i       ($signed(s_axis_tdata[6*N-1:5*N])),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  tpcr_fifo #(.WIDTH(EW), .DEPTH(tpcr_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  tpcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (q_rdata),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .radius_o    (m_axis_tdata),
    .status_o    (status)
  );

  assign m_axis_tuser = status;

  `TPCR_ASSERT_IMPLY(col_zero_a, m_axis_tvalid && m_axis_tuser == tpcr_pkg::ST_COLLINEAR, m_axis_tdata == '0)
  `TPCR_ASSERT_IMPLY(sat_max_a, m_axis_tvalid && m_axis_tuser == tpcr_pkg::ST_SATURATED, m_axis_tdata == '1)
  `TPCR_ASSERT_NEVER(q_push_full_a, q_push && q_stat.full)
  `TPCR_ASSERT_NEVER(q_pop_empty_a, q_pop && q_stat.empty)

endmodule
